// File: rtl/stack_with_reorder_ops_defines.svh
// Assertion macros for the reordering stack
`ifndef STACK_WITH_REORDER_OPS_DEFINES_SVH
`define STACK_WITH_REORDER_OPS_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define SWRO_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define SWRO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/swro_pkg.sv
// Shared types and constants for the reordering stack
`default_nettype none

package swro_pkg;

  // Built depth and register reset value
  localparam int unsigned DEPTH_DEF = 16;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  // Operation codes carried in the input beat
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_INS  = 3'd2,
    OP_DEL  = 3'd3,
    OP_REV  = 3'd4,
    OP_SORT = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REV_RD,
    ST_REV_WA,
    ST_REV_WB,
    ST_SRT_START,
    ST_SRT_LD0,
    ST_SRT_RD,
    ST_SRT_CMP,
    ST_SRT_END,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic acc;       // input beat accepted: single-step ops run now
    logic rd_pair;   // read entries i and j
    logic wr_i_b;    // write entry i with the word read from j
    logic wr_j_a;    // write entry j with the word read from i, step i and j
    logic srt_init;  // read the bottom entry
    logic srt_load;  // take bottom word as carry, start a pass
    logic srt_rd;    // read entry i
    logic srt_cmp;   // compare carry with entry i, write entry i-1
    logic srt_end;   // write carry to the top entry
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic i_lt_j;       // reverse pointers have not met
    logic i_last;       // sort index sits at the top entry
    logic at_most_one;  // at most one entry held
    logic swapped;      // current sort pass moved something
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/stack_with_reorder_ops.sv
// Top level of the bounded stack with reverse and sort operations
`default_nettype none
`include "stack_with_reorder_ops_defines.svh"

// Bounded stack of signed 32-bit words held in a single-write-port circular
// memory of DEPTH entries, with a capacity register written over its own
// channel; the user must write it only while the block is idle, which the
// block itself does not enforce. One op is in flight at a time. Push, pop,
// insert-bottom, delete-bottom and unknown ops go from IDLE through DONE to
// the result beat; the next input beat is taken once the result is loaded.
// Reverse swaps pairs through the memory. Sort runs bubble passes over the
// memory, up to n passes, bounded by the single memory write port.
// The entry memory is not cleared at reset; only held entries are read.
module stack_with_reorder_ops
  import swro_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // op[2:0], value[34:3], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // read_value[31:0], status[33:32],
                                           // fill_level[38:34], zero pad
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i      // capacity_in_use
);

  logic [4:0]  cap_q;
  cmd_t        cmd;
  dp_stat_t    dp_stat;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  fill_level;

  // Capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  swro_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .op_i        (s_axis_tdata[2:0]),
    .out_ready_i (m_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  swro_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (s_axis_tdata[2:0]),
    .value_i      (s_axis_tdata[34:3]),
    .cap_i        (cap_q),
    .stat_o       (dp_stat),
    .read_value_o (read_value),
    .status_o     (status),
    .fill_level_o (fill_level)
  );

  // Output beat packing
  assign m_axis_tdata = {1'b0, fill_level, status, read_value};

  // One op in flight: an accepted beat blocks the next cycle
  `SWRO_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // An empty refusal reports an empty stack
  `SWRO_ASSERT_IMPL(a_empty_fill, clk_i, rst_ni,
                    m_axis_tvalid && status == STAT_EMPTY, fill_level == 5'd0)
  // Only a completed op can return a word
  `SWRO_ASSERT_IMPL(a_rv_done, clk_i, rst_ni,
                    m_axis_tvalid && read_value != 32'd0, status == STAT_DONE)
  // Fill never exceeds the built depth
  `SWRO_ASSERT_IMPL(a_fill_max, clk_i, rst_ni,
                    m_axis_tvalid && DEPTH < 32, 32'(fill_level) <= DEPTH)

endmodule

`default_nettype wire

// File: rtl/swro_ctrl.sv
// Controller state machine for the reordering stack
`default_nettype none

module swro_ctrl
  import swro_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic [2:0] op_i,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output cmd_t          cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (op_i == OP_REV) state_d = ST_REV_RD;
          else if (op_i == OP_SORT)    state_d = ST_SRT_START;
          else                         state_d = ST_DONE;
        end
      end
      ST_REV_RD:    state_d = stat_i.i_lt_j ? ST_REV_WA : ST_DONE;
      ST_REV_WA:    state_d = ST_REV_WB;
      ST_REV_WB:    state_d = ST_REV_RD;
      ST_SRT_START: state_d = stat_i.at_most_one ? ST_DONE : ST_SRT_LD0;
      ST_SRT_LD0:   state_d = ST_SRT_RD;
      ST_SRT_RD:    state_d = ST_SRT_CMP;
      ST_SRT_CMP:   state_d = stat_i.i_last ? ST_SRT_END : ST_SRT_RD;
      ST_SRT_END:   state_d = stat_i.swapped ? ST_SRT_START : ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
      end
      ST_REV_RD:    cmd_o.rd_pair  = stat_i.i_lt_j;
      ST_REV_WA:    cmd_o.wr_i_b   = 1'b1;
      ST_REV_WB:    cmd_o.wr_j_a   = 1'b1;
      ST_SRT_START: cmd_o.srt_init = !stat_i.at_most_one;
      ST_SRT_LD0:   cmd_o.srt_load = 1'b1;
      ST_SRT_RD:    cmd_o.srt_rd   = 1'b1;
      ST_SRT_CMP:   cmd_o.srt_cmp  = 1'b1;
      ST_SRT_END:   cmd_o.srt_end  = 1'b1;
      ST_DONE:      cmd_o.load_out = !out_valid_q || out_ready_i;
      default:      cmd_o          = '0;
    endcase
  end

  // Output beat valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/swro_datapath.sv
// Datapath of the reordering stack: circular entry memory, pointers, sort carry
`default_nettype none

module swro_datapath
  import swro_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] value_i,
  input  wire logic [4:0]  cap_i,
  output dp_stat_t         stat_o,
  output logic [31:0]      read_value_o,
  output logic [1:0]       status_o,
  output logic [4:0]       fill_level_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 5) ? CW : 5;

  // Entry memory, physical order; bottom sits at base_q
  logic [31:0] mem [DEPTH];

  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d;
  logic [31:0]   carry_q, carry_d;
  logic          swapped_q, swapped_d;
  logic [2:0]    op_q;
  logic [1:0]    status_q;
  logic [31:0]   rd_a_q, rd_b_q;
  logic [31:0]   out_rv_q;
  logic [1:0]    out_st_q;
  logic [4:0]    out_fill_q;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] base_inc, base_dec;
  logic          full, empty, gt;
  logic [1:0]    status_d;
  logic          rd_a_en, rd_b_en, wr_en;
  logic [AW-1:0] rd_a_addr, wr_addr;
  logic [31:0]   wr_data;
  logic [CW+4:0] count_ext;

  // Logical index to physical address, wrapping at the built depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // Occupancy and pointer arithmetic
  assign cnt_m1   = count_q - CW'(1);
  assign base_inc = (base_q == AW'(DEPTH - 1)) ? '0 : base_q + AW'(1);
  assign base_dec = (base_q == '0) ? AW'(DEPTH - 1) : base_q - AW'(1);
  assign empty    = (count_q == '0);
  assign full     = (XW'(count_q) >= XW'(cap_i)) || (count_q == CW'(DEPTH));
  assign gt       = $signed(carry_q) > $signed(rd_a_q);

  // Status toward the controller
  assign stat_o.i_lt_j      = i_q < j_q;
  assign stat_o.i_last      = (CW'(i_q) == cnt_m1);
  assign stat_o.at_most_one = (count_q <= CW'(1));
  assign stat_o.swapped     = swapped_q;

  // Result status of a single-step op
  always_comb begin
    status_d = STAT_DONE;
    unique case (op_i)
      OP_PUSH, OP_INS: if (full)  status_d = STAT_FULL;
      OP_POP, OP_DEL:  if (empty) status_d = STAT_EMPTY;
      default:         status_d = STAT_DONE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_addr = phys(base_q, i_q);
    wr_en     = 1'b0;
    wr_addr   = phys(base_q, i_q);
    wr_data   = value_i;
    priority if (cmd_i.acc) begin
      if (op_i == OP_POP && !empty) begin
        rd_a_en   = 1'b1;
        rd_a_addr = phys(base_q, cnt_m1[AW-1:0]);
      end
      if (op_i == OP_PUSH && !full) begin
        wr_en   = 1'b1;
        wr_addr = phys(base_q, count_q[AW-1:0]);
      end
      if (op_i == OP_INS && !full) begin
        wr_en   = 1'b1;
        wr_addr = base_dec;
      end
    end else if (cmd_i.rd_pair) begin
      rd_a_en = 1'b1;
      rd_b_en = 1'b1;
    end else if (cmd_i.wr_i_b) begin
      wr_en   = 1'b1;
      wr_data = rd_b_q;
    end else if (cmd_i.wr_j_a) begin
      wr_en   = 1'b1;
      wr_addr = phys(base_q, j_q);
      wr_data = rd_a_q;
    end else if (cmd_i.srt_init) begin
      rd_a_en   = 1'b1;
      rd_a_addr = base_q;
    end else if (cmd_i.srt_rd) begin
      rd_a_en = 1'b1;
    end else if (cmd_i.srt_cmp) begin
      wr_en   = 1'b1;
      wr_addr = phys(base_q, i_q - AW'(1));
      wr_data = gt ? rd_a_q : carry_q;
    end else if (cmd_i.srt_end) begin
      wr_en   = 1'b1;
      wr_addr = phys(base_q, cnt_m1[AW-1:0]);
      wr_data = carry_q;
    end
  end

  // Memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en)   mem[wr_addr] <= wr_data;
    if (rd_a_en) rd_a_q <= mem[rd_a_addr];
    if (rd_b_en) rd_b_q <= mem[phys(base_q, j_q)];
  end

  // Pointer, count and sort state updates
  always_comb begin
    base_d    = base_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    carry_d   = carry_q;
    swapped_d = swapped_q;
    if (cmd_i.acc) begin
      i_d = '0;
      j_d = empty ? '0 : cnt_m1[AW-1:0];
      unique case (op_i)
        OP_PUSH: if (!full)  count_d = count_q + CW'(1);
        OP_POP:  if (!empty) count_d = cnt_m1;
        OP_INS: begin
          if (!full) begin
            base_d  = base_dec;
            count_d = count_q + CW'(1);
          end
        end
        OP_DEL: begin
          if (!empty) begin
            base_d  = base_inc;
            count_d = cnt_m1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.wr_j_a) begin
      i_d = i_q + AW'(1);
      j_d = j_q - AW'(1);
    end
    if (cmd_i.srt_load) begin
      carry_d   = rd_a_q;
      swapped_d = 1'b0;
      i_d       = AW'(1);
    end
    if (cmd_i.srt_cmp) begin
      i_d = i_q + AW'(1);
      if (gt) swapped_d = 1'b1;
      else    carry_d   = rd_a_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      count_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      swapped_q <= 1'b0;
    end else begin
      base_q    <= base_d;
      count_q   <= count_d;
      i_q       <= i_d;
      j_q       <= j_d;
      swapped_q <= swapped_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (cmd_i.acc) begin
      op_q     <= op_i;
      status_q <= status_d;
    end
    if (cmd_i.load_out) begin
      out_rv_q   <= (op_q == OP_POP && status_q == STAT_DONE) ? rd_a_q : '0;
      out_st_q   <= status_q;
      out_fill_q <= count_ext[4:0];
    end
  end

  assign count_ext    = {5'b0, count_q};
  assign read_value_o = out_rv_q;
  assign status_o     = out_st_q;
  assign fill_level_o = out_fill_q;

endmodule

`default_nettype wire
